// ===== src/wca_pkg.sv =====
`default_nettype none
package wca_pkg;

    localparam int DIMENSIONS  = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int IN_SAMPLES  = 4;
    localparam int WEIGHT_BITS = 16;
    localparam int PAIRS       = DIMENSIONS * (DIMENSIONS + 1) / 2;
    localparam int ACC_N       = PAIRS + DIMENSIONS;
    localparam int ACC_AW      = $clog2(ACC_N);
    localparam int DIM_W       = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int ADIMS_BITS  = 3;
    localparam int ACC_BITS    = 64;
    localparam int WT_BITS     = 40;
    localparam int TERM_BITS   = 2 * SAMPLE_BITS;
    localparam int PROD_BITS   = TERM_BITS + WEIGHT_BITS;
    localparam int DIV_BITS    = 128;
    localparam int IDX_BITS    = 2;
    localparam int MEAN_BITS   = 24;
    localparam int COV_BITS    = 48;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int IN_DATA_W   = IN_SAMPLES * SAMPLE_BITS + WEIGHT_BITS;
    localparam int OUT_FIELD_W = 2 * IDX_BITS + MEAN_BITS + COV_BITS;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int USER_IN_W   = 2;

    localparam logic [1:0] OP_ACC  = 2'd0;
    localparam logic [1:0] OP_CLR  = 2'd1;
    localparam logic [1:0] OP_REP  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [1:0]                            op;
        logic [DIMENSIONS-1:0][SAMPLE_BITS-1:0] mag;
        logic [DIMENSIONS-1:0]                 neg;
        logic [WEIGHT_BITS-1:0]                weight;
    } t_item;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [WT_BITS-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } t_div_rsp;

    // Row-major slot of pair (i,j), i <= j, over the upper triangle.
    function automatic logic [ACC_AW-1:0] pair_index(input logic [DIM_W-1:0] i,
                                                     input logic [DIM_W-1:0] j);
        int unsigned ii;
        int unsigned jj;
        int unsigned k;
        ii = i;
        jj = j;
        k  = ii * (2 * DIMENSIONS - ii + 1) / 2 + (jj - ii);
        return ACC_AW'(k);
    endfunction

    // Sign and magnitude clamped to a signed field of the given width.
    function automatic logic [63:0] sat_signed(input logic neg,
                                               input logic [DIV_BITS-1:0] q,
                                               input int unsigned bits);
        logic [DIV_BITS-1:0] lim;
        logic [63:0]         res;
        lim = DIV_BITS'(1) << (bits - 1);
        if (neg) begin
            if (q > lim) res = lim[63:0];
            else         res = ~q[63:0] + 64'd1;
        end else begin
            if (q > lim - DIV_BITS'(1)) res = lim[63:0] - 64'd1;
            else                        res = q[63:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/wca_fifo.sv =====
`default_nettype none
module wca_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wca_pkg::t_item       i_data,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output wca_pkg::t_item       o_data
);
    wca_pkg::t_item                r_mem [wca_pkg::FIFO_DEPTH];
    logic [wca_pkg::FIFO_AW-1:0]   r_wptr;
    logic [wca_pkg::FIFO_AW-1:0]   r_rptr;
    logic [wca_pkg::FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (wca_pkg::FIFO_AW + 1)'(wca_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wptr <= r_wptr + 1'b1;
            if (i_pop && !o_empty) r_rptr <= r_rptr + 1'b1;
            if ((i_push && !o_full) && !(i_pop && !o_empty)) r_count <= r_count + 1'b1;
            else if (!(i_push && !o_full) && (i_pop && !o_empty)) r_count <= r_count - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== src/wca_front.sv =====
`default_nettype none
module wca_front (
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [wca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire [wca_pkg::USER_IN_W-1:0]     s_axis_tuser,
    input  wire                              i_full,
    output logic                             o_push,
    output wca_pkg::t_item                   o_item
);
    // Take a beat whenever the queue has room; drop the unused action code.
    assign s_axis_tready = !i_full;
    assign o_push = s_axis_tvalid && !i_full && (s_axis_tuser != wca_pkg::OP_NONE);

    always_comb begin
        logic [wca_pkg::SAMPLE_BITS-1:0] x;
        o_item.op     = s_axis_tuser;
        o_item.weight = s_axis_tdata[wca_pkg::IN_SAMPLES*wca_pkg::SAMPLE_BITS +:
                                     wca_pkg::WEIGHT_BITS];
        for (int d = 0; d < wca_pkg::DIMENSIONS; d++) begin
            if (d < wca_pkg::IN_SAMPLES) x = s_axis_tdata[d*wca_pkg::SAMPLE_BITS +:
                                                          wca_pkg::SAMPLE_BITS];
            else                         x = '0;
            o_item.neg[d] = x[wca_pkg::SAMPLE_BITS-1];
            o_item.mag[d] = x[wca_pkg::SAMPLE_BITS-1] ? (~x + 1'b1) : x;
        end
    end
endmodule
`default_nettype wire

// ===== src/wca_div.sv =====
`default_nettype none
module wca_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wca_pkg::t_div_req  i_req,
    output wca_pkg::t_div_rsp  o_rsp
);
    localparam int CNT_W = $clog2(wca_pkg::DIV_BITS);

    logic [wca_pkg::DIV_BITS-1:0] r_nq;
    logic [wca_pkg::WT_BITS-1:0]  r_rem;
    logic [wca_pkg::WT_BITS-1:0]  r_den;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    logic [wca_pkg::WT_BITS:0]    rem2;
    logic [wca_pkg::WT_BITS:0]    diff;
    logic                         ge;

    // One quotient bit a cycle, restoring.
    assign rem2 = {r_rem, r_nq[wca_pkg::DIV_BITS-1]};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = (rem2 >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_nq;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_nq  <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[wca_pkg::DIV_BITS-2:0], ge};
            r_rem <= ge ? diff[wca_pkg::WT_BITS-1:0] : rem2[wca_pkg::WT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == CNT_W'(wca_pkg::DIV_BITS - 1));
                if (r_cnt == CNT_W'(wca_pkg::DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/wca_back.sv =====
`default_nettype none
module wca_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [wca_pkg::ADIMS_BITS-1:0]       i_active_dims,
    input  wire                                 i_empty,
    input  wca_pkg::t_item                      i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [wca_pkg::IDX_BITS-1:0]        o_row,
    output logic [wca_pkg::IDX_BITS-1:0]        o_col,
    output logic [wca_pkg::MEAN_BITS-1:0]       o_mean,
    output logic [wca_pkg::COV_BITS-1:0]        o_cov,
    output logic                                o_status,
    output logic                                o_last
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ACC     = 4'd1;
    localparam logic [3:0] S_DRAIN   = 4'd2;
    localparam logic [3:0] S_MEAN_GO = 4'd3;
    localparam logic [3:0] S_MEAN_W  = 4'd4;
    localparam logic [3:0] S_MUL_GO  = 4'd5;
    localparam logic [3:0] S_MUL_RUN = 4'd6;
    localparam logic [3:0] S_T_W     = 4'd7;
    localparam logic [3:0] S_D_GO    = 4'd8;
    localparam logic [3:0] S_COV_W   = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    localparam int AB = wca_pkg::ACC_BITS;
    localparam int MUL_CNT_W = $clog2(AB);
    localparam logic [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    logic [3:0]                       r_state;
    wca_pkg::t_item                   r_item;
    logic [wca_pkg::DIM_W-1:0]        r_i;
    logic [wca_pkg::DIM_W-1:0]        r_j;
    logic [wca_pkg::DIM_W-1:0]        r_last_idx;
    logic                             r_cterm;
    logic                             r_empty;

    logic [AB-1:0]                    r_acc [wca_pkg::ACC_N];
    logic [wca_pkg::WT_BITS-1:0]      r_wt;

    logic                             r_s1_v;
    logic                             r_s1_neg;
    logic [wca_pkg::ACC_AW-1:0]       r_s1_k;
    logic [wca_pkg::TERM_BITS-1:0]    r_s1_p;
    logic                             r_s2_v;
    logic                             r_s2_neg;
    logic [wca_pkg::ACC_AW-1:0]       r_s2_k;
    logic [wca_pkg::PROD_BITS-1:0]    r_s2_p;

    logic [AB-1:0]                    r_smag_i;
    logic                             r_sneg_i;
    logic [AB-1:0]                    r_ma;
    logic [2*AB-1:0]                  r_mp;
    logic [MUL_CNT_W-1:0]             r_mcnt;
    logic                             r_tneg;
    logic [AB-1:0]                    r_t;
    logic                             r_dneg;
    logic [wca_pkg::MEAN_BITS-1:0]    r_mean;
    logic [wca_pkg::COV_BITS-1:0]     r_cov;

    logic                             r_div_start;
    logic [wca_pkg::DIV_BITS-1:0]     r_div_num;
    wca_pkg::t_div_req                div_req;
    wca_pkg::t_div_rsp                div_rsp;

    logic                             r_out_valid;
    logic [wca_pkg::IDX_BITS-1:0]     r_out_row;
    logic [wca_pkg::IDX_BITS-1:0]     r_out_col;
    logic [wca_pkg::MEAN_BITS-1:0]    r_out_mean;
    logic [wca_pkg::COV_BITS-1:0]     r_out_cov;
    logic                             r_out_status;
    logic                             r_out_last;

    logic [wca_pkg::ADIMS_BITS-1:0]   dims;
    logic [wca_pkg::ACC_AW-1:0]       rd_addr;
    logic [AB-1:0]                    rd_data;
    logic [AB-1:0]                    rd_mag;
    logic [wca_pkg::SAMPLE_BITS-1:0]  op_a;
    logic [wca_pkg::SAMPLE_BITS-1:0]  op_b;
    logic [wca_pkg::ACC_AW-1:0]       issue_k;
    logic [AB:0]                      sum;
    logic [AB-1:0]                    acc_new;
    logic [AB:0]                      mp_hi;
    logic [2*AB-1:0]                  mp_next;
    logic [AB:0]                      dval;
    logic [AB:0]                      dmag;
    logic                             pop;
    logic                             out_free;
    logic [wca_pkg::WT_BITS:0]        wt_sum;

    // Clamp active dimensions to 1..DIMENSIONS.
    always_comb begin
        dims = i_active_dims;
        if (dims == '0) dims = wca_pkg::ADIMS_BITS'(1);
        if (dims > wca_pkg::ADIMS_BITS'(wca_pkg::DIMENSIONS))
            dims = wca_pkg::ADIMS_BITS'(wca_pkg::DIMENSIONS);
    end

    assign pop      = (r_state == S_IDLE) && !i_empty;
    assign o_pop    = pop;
    assign out_free = !r_out_valid || i_ready;

    // Single read port onto the accumulators.
    always_comb begin
        case (r_state)
            S_MEAN_GO: rd_addr = wca_pkg::ACC_AW'(wca_pkg::PAIRS) + wca_pkg::ACC_AW'(r_i);
            S_MUL_GO:  rd_addr = wca_pkg::ACC_AW'(wca_pkg::PAIRS) + wca_pkg::ACC_AW'(r_j);
            S_D_GO:    rd_addr = wca_pkg::pair_index(r_i, r_j);
            default:   rd_addr = r_s2_k;
        endcase
    end
    assign rd_data = r_acc[rd_addr];
    assign rd_mag  = rd_data[AB-1] ? (~rd_data + 1'b1) : rd_data;

    // Accumulate term issue: component term uses 1 as second factor.
    assign op_a    = r_item.mag[r_i];
    assign op_b    = r_cterm ? wca_pkg::SAMPLE_BITS'(1) : r_item.mag[r_j];
    assign issue_k = r_cterm ? (wca_pkg::ACC_AW'(wca_pkg::PAIRS) + wca_pkg::ACC_AW'(r_i))
                             : wca_pkg::pair_index(r_i, r_j);

    // Saturating add of the signed term into its accumulator.
    always_comb begin
        if (r_s2_neg) sum = {rd_data[AB-1], rd_data} - (AB+1)'(r_s2_p);
        else          sum = {rd_data[AB-1], rd_data} + (AB+1)'(r_s2_p);
        if (sum[AB] != sum[AB-1]) acc_new = sum[AB] ? ACC_MIN : ACC_MAX;
        else                      acc_new = sum[AB-1:0];
    end

    // Shift-add multiplier step for |s_i|*|s_j|.
    assign mp_hi   = r_mp[0] ? ({1'b0, r_mp[2*AB-1:AB]} + {1'b0, r_ma})
                             : {1'b0, r_mp[2*AB-1:AB]};
    assign mp_next = {mp_hi, r_mp[AB-1:1]};

    assign dval = {rd_data[AB-1], rd_data} - {r_t[AB-1], r_t};
    assign dmag = dval[AB] ? (~dval + 1'b1) : dval;

    assign wt_sum = {1'b0, r_wt} + (wca_pkg::WT_BITS+1)'(i_item.weight);

    assign div_req.start = r_div_start;
    assign div_req.num   = r_div_num;
    assign div_req.den   = r_wt;

    wca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Accumulators and total weight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wca_pkg::ACC_N; k++) r_acc[k] <= '0;
            r_wt <= '0;
        end else begin
            if (pop && i_item.op == wca_pkg::OP_CLR) begin
                for (int k = 0; k < wca_pkg::ACC_N; k++) r_acc[k] <= '0;
                r_wt <= '0;
            end else begin
                if (r_s2_v) r_acc[r_s2_k] <= acc_new;
                if (pop && i_item.op == wca_pkg::OP_ACC) begin
                    r_wt <= wt_sum[wca_pkg::WT_BITS] ? '1 : wt_sum[wca_pkg::WT_BITS-1:0];
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_item;
            r_mean <= '0;
            r_cov  <= '0;
        end
        r_s1_neg <= r_cterm ? r_item.neg[r_i] : (r_item.neg[r_i] ^ r_item.neg[r_j]);
        r_s1_k   <= issue_k;
        r_s1_p   <= wca_pkg::TERM_BITS'(op_a) * wca_pkg::TERM_BITS'(op_b);
        r_s2_neg <= r_s1_neg;
        r_s2_k   <= r_s1_k;
        r_s2_p   <= wca_pkg::PROD_BITS'(r_s1_p) * wca_pkg::PROD_BITS'(r_item.weight);
        case (r_state)
            S_MEAN_GO: begin
                r_sneg_i  <= rd_data[AB-1];
                r_smag_i  <= rd_mag;
                r_div_num <= wca_pkg::DIV_BITS'(rd_mag) << 8;
            end
            S_MEAN_W: begin
                if (div_rsp.done)
                    r_mean <= wca_pkg::MEAN_BITS'(wca_pkg::sat_signed(
                                  r_sneg_i, div_rsp.quot, wca_pkg::MEAN_BITS));
            end
            S_MUL_GO: begin
                r_ma   <= r_smag_i;
                r_mp   <= {{AB{1'b0}}, rd_mag};
                r_tneg <= r_sneg_i ^ rd_data[AB-1];
            end
            S_MUL_RUN: begin
                r_mp      <= mp_next;
                r_div_num <= mp_next;
            end
            S_T_W: begin
                if (div_rsp.done)
                    r_t <= wca_pkg::sat_signed(r_tneg, div_rsp.quot, AB);
            end
            S_D_GO: begin
                r_dneg    <= dval[AB];
                r_div_num <= wca_pkg::DIV_BITS'(dmag) << 8;
            end
            S_COV_W: begin
                if (div_rsp.done)
                    r_cov <= wca_pkg::COV_BITS'(wca_pkg::sat_signed(
                                 r_dneg, div_rsp.quot, wca_pkg::COV_BITS));
            end
            default: begin
            end
        endcase
        if (r_state == S_EMIT && out_free) begin
            r_out_row    <= wca_pkg::IDX_BITS'(r_i);
            r_out_col    <= wca_pkg::IDX_BITS'(r_j);
            r_out_mean   <= r_mean;
            r_out_cov    <= r_cov;
            r_out_status <= r_empty ? wca_pkg::STATUS_EMPTY : wca_pkg::STATUS_OK;
            r_out_last   <= r_empty || (r_i == r_last_idx && r_j == r_last_idx);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_last_idx  <= '0;
            r_cterm     <= 1'b0;
            r_empty     <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_mcnt      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v      <= (r_state == S_ACC);
            r_s2_v      <= r_s1_v;
            // Kick the divider for the mean, for s_i*s_j/W and for the covariance.
            r_div_start <= (r_state == S_MEAN_GO) || (r_state == S_D_GO) ||
                           (r_state == S_MUL_RUN && r_mcnt == MUL_CNT_W'(AB - 1));
            if (r_state == S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (i_ready)                  r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_last_idx <= wca_pkg::DIM_W'(dims - 1'b1);
                        r_i        <= '0;
                        r_j        <= '0;
                        r_cterm    <= 1'b1;
                        r_empty    <= (i_item.op == wca_pkg::OP_REP) && (r_wt == '0);
                        case (i_item.op)
                            wca_pkg::OP_ACC: r_state <= S_ACC;
                            wca_pkg::OP_REP: begin
                                if (r_wt == '0) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_MEAN_GO;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ACC: begin
                    if (r_cterm) begin
                        r_cterm <= 1'b0;
                        r_j     <= r_i;
                    end else if (r_j == r_last_idx) begin
                        if (r_i == r_last_idx) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_cterm <= 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) r_state <= S_IDLE;
                end
                S_MEAN_GO: begin
                    r_state <= S_MEAN_W;
                end
                S_MEAN_W: begin
                    if (div_rsp.done) begin
                        r_j     <= r_i;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO: begin
                    r_mcnt  <= '0;
                    r_state <= S_MUL_RUN;
                end
                S_MUL_RUN: begin
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == MUL_CNT_W'(AB - 1)) begin
                        r_state <= S_T_W;
                    end
                end
                S_T_W: begin
                    if (div_rsp.done) r_state <= S_D_GO;
                end
                S_D_GO: begin
                    r_state <= S_COV_W;
                end
                S_COV_W: begin
                    if (div_rsp.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_empty) begin
                            r_state <= S_IDLE;
                        end else if (r_j == r_last_idx) begin
                            if (r_i == r_last_idx) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_MEAN_GO;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_row    = r_out_row;
    assign o_col    = r_out_col;
    assign o_mean   = r_out_mean;
    assign o_cov    = r_out_cov;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_v && !r_s2_v))
        else $error("accumulate pipeline busy while idle");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> r_out_valid)
        else $error("result not registered on emit");

    a_upper_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_RUN || r_state == S_D_GO) |-> (r_j >= r_i))
        else $error("pair outside upper triangle");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MEAN_W || r_state == S_T_W || r_state == S_COV_W))
        else $error("divider finished with nobody waiting");
endmodule
`default_nettype wire

// ===== src/weighted_covariance_accumulator.sv =====
`default_nettype none
// Weighted mean and covariance accumulator.
// Input stream (s_axis): tuser carries the action (accumulate, clear, report),
// tdata the four 16-bit signed sample components and the Q8.8 weight. Beats
// land in a four-deep queue; the back end drains it one item at a time, so a
// stalled output side only holds the input once the queue fills.
// Accumulate: one issue a cycle into a two-stage multiply pipeline, one term for
// each of the n + n(n+1)/2 component and pair terms of n active dimensions.
// Clear: zeroes all sums and the total weight. Report: per row one 128-step
// divide for the mean, per pair a 64-step shift-add multiply and two 128-step
// divides, all on the one shared serial divider.
// Output stream (m_axis): one beat per upper-triangle pair, tlast on the final
// one; tuser carries status (set on the single beat of a report with zero
// total weight). The result register holds while tready is low, and the
// sequencer waits on it before producing the next pair.
// APB register 0 (byte 0): active_dims, reset 4; write only while idle.
// Reset (synchronous, active low) zeroes all sums and the total weight,
// empties the queue and drops any pending result.
module weighted_covariance_accumulator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_0, sample_1, sample_2, sample_3, weight
    input  wire [wca_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // action
    input  wire [wca_pkg::USER_IN_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // row, col, mean_row, covariance, zero pad
    output logic [wca_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status
    output logic [0:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [2:0]                           paddr,
    input  wire [31:0]                          pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    logic [wca_pkg::ADIMS_BITS-1:0]  r_active_dims;
    logic                            full;
    logic                            empty;
    logic                            push;
    logic                            pop;
    wca_pkg::t_item                  front_item;
    wca_pkg::t_item                  queue_item;
    logic [wca_pkg::IDX_BITS-1:0]    row;
    logic [wca_pkg::IDX_BITS-1:0]    col;
    logic [wca_pkg::MEAN_BITS-1:0]   mean;
    logic [wca_pkg::COV_BITS-1:0]    cov;
    logic                            status;

    // Register file: only active_dims, at byte address 0.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-wca_pkg::ADIMS_BITS){1'b0}}, r_active_dims};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dims <= wca_pkg::ADIMS_BITS'(4);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_active_dims <= pwdata[wca_pkg::ADIMS_BITS-1:0];
        end
    end

    wca_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (full),
        .o_push        (push),
        .o_item        (front_item)
    );

    wca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (queue_item)
    );

    wca_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active_dims (r_active_dims),
        .i_empty       (empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_row         (row),
        .o_col         (col),
        .o_mean        (mean),
        .o_cov         (cov),
        .o_status      (status),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{(wca_pkg::OUT_DATA_W - wca_pkg::OUT_FIELD_W){1'b0}},
                           cov, mean, col, row};
    assign m_axis_tuser = status;
endmodule
`default_nettype wire
